FILE: hdl/sha256_pkg.sv
// shared types, round constants and initial hash values of the sha-256 stream hasher
package sha256_pkg;

   localparam int unsigned WORDS    = 8;
   localparam int unsigned ROUNDS   = 64;
   localparam int unsigned BLK_BITS = 512;

   localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [0:WORDS-1] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef enum logic [1:0] {
      BYTE_MSG,
      BYTE_MARK,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       msg_last;
   } sha256_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_last;
   } sha256_rsp_type;

   typedef struct packed {
      logic         shift_en;
      byte_sel_type byte_sel;
      logic         start_block;
      logic         round_en;
      logic [5:0]   round_idx;
      logic         update_en;
      logic         load_digest;
   } sha256_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic       out_busy;
   } sha256_stat_type;

endpackage

FILE: hdl/sha256_stream_hasher_top.sv
// top level of the sha-256 stream hasher: controller and datapath
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_data  (msg_byte, byte_valid, msg_last)
//   rsp      out  rsp_valid/rsp_ready    rsp_data  (digest_word, word_index, digest_last)
//
// each accepted transaction is taken while idle; a 64th data byte starts the 64 rounds of
// the single shared round unit and one chaining update.
// a last transaction adds the pad bytes, then the rounds and an update per padded block
// (one or two blocks) and one digest load, then eight digest words leave.
// reset is synchronous; there is no clearing pass, the block buffer is overwritten.
// req_ready is low outside idle (rounds, update, padding, digest load); a stalled rsp only blocks the next digest.
module sha256_stream_hasher_top
   import sha256_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  sha256_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output sha256_rsp_type rsp_data
);

   sha256_cmd_type  cmd;
   sha256_stat_type stat;

   sha256_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .byte_valid (req_data.byte_valid),
      .msg_last   (req_data.msg_last),
      .stat       (stat),
      .cmd        (cmd)
   );

   sha256_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .msg_byte  (req_data.msg_byte),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/sha256_dp.sv
// datapath: block shift line, round unit, chaining words, length count and digest output bank
module sha256_dp
   import sha256_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  sha256_cmd_type  cmd,
   input  logic [7:0]      msg_byte,
   output sha256_stat_type stat,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output sha256_rsp_type  rsp_data
);

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   logic [BLK_BITS-1:0] blk_ff, blk_in;
   logic [31:0]         v_ff   [WORDS];
   logic [31:0]         v_in   [WORDS];
   logic [31:0]         hw_ff  [WORDS];
   logic [31:0]         hw_in  [WORDS];
   logic [31:0]         dig_ff [WORDS];
   logic [31:0]         dig_in [WORDS];
   logic [63:0]         len_ff, len_in;
   logic [5:0]          fill_ff, fill_in;
   logic [2:0]          idx_ff, idx_in;
   logic                ovalid_ff, ovalid_in;

   logic [7:0]  byte_mux;
   logic [63:0] len_sh;
   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2, ch, maj;
   logic        rsp_take;

   assign w0  = blk_ff[BLK_BITS-1 -: 32];
   assign w1  = blk_ff[BLK_BITS-1-32 -: 32];
   assign w9  = blk_ff[BLK_BITS-1-9*32 -: 32];
   assign w14 = blk_ff[BLK_BITS-1-14*32 -: 32];
   assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

   assign ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1  = v_ff[7] + big_sigma1(v_ff[4]) + ch + ROUND_K[cmd.round_idx] + w0;
   assign t2  = big_sigma0(v_ff[0]) + maj;

   assign len_sh = len_ff >> {~fill_ff[2:0], 3'b000};

   always_comb begin
      unique case (cmd.byte_sel)
         BYTE_MSG:  byte_mux = msg_byte;
         BYTE_MARK: byte_mux = PAD_MARK;
         BYTE_ZERO: byte_mux = 8'h00;
         BYTE_LEN:  byte_mux = len_sh[7:0];
         default:   byte_mux = 8'h00;
      endcase
   end

   assign rsp_take = ovalid_ff && rsp_ready;

   always_comb begin
      blk_in    = blk_ff;
      v_in      = v_ff;
      hw_in     = hw_ff;
      dig_in    = dig_ff;
      len_in    = len_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      ovalid_in = ovalid_ff;

      if (cmd.shift_en) begin
         blk_in  = {blk_ff[BLK_BITS-9:0], byte_mux};
         fill_in = fill_ff + 6'd1;
         if (cmd.byte_sel == BYTE_MSG) begin
            len_in = len_ff + 64'd8;
         end
      end
      if (cmd.start_block) begin
         v_in = hw_ff;
      end
      if (cmd.round_en) begin
         blk_in = {blk_ff[BLK_BITS-33:0], w_new};
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
      end
      if (cmd.update_en) begin
         for (int i = 0; i < WORDS; i++) begin
            hw_in[i] = hw_ff[i] + v_ff[i];
         end
      end

      if (rsp_take) begin
         for (int i = 0; i < WORDS-1; i++) begin
            dig_in[i] = dig_ff[i+1];
         end
         idx_in = idx_ff + 3'd1;
         if (idx_ff == 3'(WORDS-1)) begin
            ovalid_in = 1'b0;
         end
      end
      if (cmd.load_digest) begin
         dig_in    = hw_ff;
         hw_in     = INIT_HASH;
         len_in    = '0;
         idx_in    = '0;
         ovalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      v_ff   <= v_in;
      dig_ff <= dig_in;
      if (reset) begin
         hw_ff     <= INIT_HASH;
         len_ff    <= '0;
         fill_ff   <= '0;
         idx_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         hw_ff     <= hw_in;
         len_ff    <= len_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign stat.fill     = fill_ff;
   assign stat.out_busy = ovalid_ff;

   assign rsp_valid            = ovalid_ff;
   assign rsp_data.digest_word = dig_ff[0];
   assign rsp_data.word_index  = idx_ff;
   assign rsp_data.digest_last = (idx_ff == 3'(WORDS-1));

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_en |=> fill_ff == $past(fill_ff) + 6'd1)
      else $error("block fill count did not advance by one");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_digest |-> !ovalid_ff)
      else $error("digest loaded over words not yet delivered");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      cmd.load_digest |=> ovalid_ff && idx_ff == 3'd0 && len_ff == 64'd0)
      else $error("digest output did not start at word zero");

endmodule

FILE: hdl/sha256_ctrl.sv
// controller: byte intake, round sequencing, padding steps and digest hand-off
module sha256_ctrl
   import sha256_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            byte_valid,
   input  logic            msg_last,
   input  sha256_stat_type stat,
   output sha256_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_UPDATE,
      ST_PAD,
      ST_FINAL
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic       ready_ff, ready_in;
   logic       last_pend_ff, last_pend_in;
   logic       pad_ff, pad_in;
   logic       mark_ff, mark_in;
   logic       len_ok_ff, len_ok_in;
   logic       fin_ff, fin_in;
   logic       accept;
   logic       blk_full;

   assign accept   = req_valid && ready_ff;
   assign blk_full = (stat.fill == 6'h3f);

   always_comb begin
      cmd          = '0;
      cmd.byte_sel = BYTE_MSG;
      cmd.round_idx = rnd_ff;
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      last_pend_in = last_pend_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      len_ok_in    = len_ok_ff;
      fin_in       = fin_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (byte_valid) begin
                  cmd.shift_en = 1'b1;
               end
               if (byte_valid && blk_full) begin
                  cmd.start_block = 1'b1;
                  last_pend_in    = msg_last;
                  rnd_in          = '0;
                  state_in        = ST_ROUND;
               end else if (msg_last) begin
                  pad_in    = 1'b1;
                  mark_in   = 1'b0;
                  len_ok_in = 1'b0;
                  fin_in    = 1'b0;
                  state_in  = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 6'd1;
            if (rnd_ff == 6'(ROUNDS-1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update_en = 1'b1;
            priority if (pad_ff && fin_ff) begin
               state_in = ST_FINAL;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else if (last_pend_ff) begin
               last_pend_in = 1'b0;
               pad_in       = 1'b1;
               mark_in      = 1'b0;
               len_ok_in    = 1'b0;
               fin_in       = 1'b0;
               state_in     = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            cmd.shift_en = 1'b1;
            priority if (!mark_ff) begin
               cmd.byte_sel = BYTE_MARK;
            end else if (len_ok_ff && stat.fill[5:3] == 3'b111) begin
               cmd.byte_sel = BYTE_LEN;
            end else begin
               cmd.byte_sel = BYTE_ZERO;
            end
            mark_in = 1'b1;
            if (blk_full) begin
               cmd.start_block = 1'b1;
               rnd_in          = '0;
               state_in        = ST_ROUND;
               if (mark_ff && len_ok_ff) begin
                  fin_in = 1'b1;
               end else begin
                  len_ok_in = 1'b1;
               end
            end else if (!mark_ff) begin
               len_ok_in = (stat.fill[5:3] != 3'b111);
            end
         end
         ST_FINAL: begin
            if (!stat.out_busy) begin
               cmd.load_digest = 1'b1;
               pad_in          = 1'b0;
               fin_in          = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         ready_ff     <= 1'b1;
         last_pend_ff <= 1'b0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         len_ok_ff    <= 1'b0;
         fin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         ready_ff     <= ready_in;
         last_pend_ff <= last_pend_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         len_ok_ff    <= len_ok_in;
         fin_ff       <= fin_in;
      end
   end

   assign req_ready = ready_ff;

   a_block_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start_block |=> state_ff == ST_ROUND && rnd_ff == 6'd0)
      else $error("compression did not start at round zero");

   a_no_shift_in_round: assert property (@(posedge clock) disable iff (reset)
      !(cmd.round_en && cmd.shift_en))
      else $error("byte shifted into block during a round");

endmodule

FILE: tb/sha256_stream_hasher_top_tb.sv
// self-checking testbench for the sha-256 stream hasher with its own digest predictor
module sha256_stream_hasher_top_tb
   import sha256_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BLOCK_BYTES    = 64;
   localparam int unsigned LENGTH_OFFSET  = 56;
   localparam int unsigned MAX_GAP        = 18;
   localparam int unsigned ITEM_TARGET    = 330;
   localparam int unsigned PRESSURE_HOLD  = 400;
   localparam int unsigned QUIET_CYCLES   = 300;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   sha256_req_type req_data;
   logic           rsp_valid;
   logic           rsp_ready;
   sha256_rsp_type rsp_data;

   logic [31:0]    chain_words [WORDS];
   logic [7:0]     block_bytes [BLOCK_BYTES];
   int unsigned    block_fill;
   logic [63:0]    message_bits;
   sha256_rsp_type pending_digest_words [$];

   int unsigned    mismatch_count = 0;
   int unsigned    sent_items = 0;
   int unsigned    rsp_wait = 0;
   int unsigned    hold_cycles = 0;
   bit             req_idle_on = 1'b1;
   bit             rsp_idle_on = 1'b1;

   sha256_stream_hasher_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void start_new_message();
      for (int i = 0; i < WORDS; i++) chain_words[i] = INIT_HASH[i];
      block_fill   = 0;
      message_bits = '0;
   endfunction

   function automatic void compress_block_bytes();
      logic [31:0] sched [ROUNDS];
      logic [31:0] v [WORDS];
      logic [31:0] s0;
      logic [31:0] s1;
      logic [31:0] t1;
      logic [31:0] t2;
      for (int t = 0; t < 16; t++) begin
         sched[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                     block_bytes[4*t+3]};
      end
      for (int t = 16; t < ROUNDS; t++) begin
         s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
      end
      for (int i = 0; i < WORDS; i++) v[i] = chain_words[i];
      for (int t = 0; t < ROUNDS; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + sched[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < WORDS; i++) chain_words[i] = chain_words[i] + v[i];
   endfunction

   function automatic void hash_item(input sha256_req_type item);
      if (item.byte_valid) begin
         block_bytes[block_fill] = item.msg_byte;
         message_bits = message_bits + 64'd8;
         block_fill = (block_fill + 1) % BLOCK_BYTES;
         if (block_fill == 0) compress_block_bytes();
      end
      if (item.msg_last) begin
         block_bytes[block_fill] = PAD_MARK;
         for (int i = block_fill + 1; i < BLOCK_BYTES; i++) block_bytes[i] = 8'h00;
         if (block_fill >= LENGTH_OFFSET) begin
            compress_block_bytes();
            for (int i = 0; i < LENGTH_OFFSET; i++) block_bytes[i] = 8'h00;
         end
         for (int i = 0; i < 8; i++) block_bytes[LENGTH_OFFSET + i] = message_bits[63 - 8*i -: 8];
         compress_block_bytes();
         for (int i = 0; i < WORDS; i++) begin
            pending_digest_words.push_back('{digest_word: chain_words[i],
                                             word_index:  3'(i),
                                             digest_last: (i == WORDS - 1)});
         end
         start_new_message();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t ns: %s got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_item(input sha256_req_type item);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      hash_item(item);
      if (item.byte_valid || item.msg_last) sent_items++;
   endtask

   task automatic send_message(input int unsigned length, input bit separate_end,
                               input int unsigned noise_pct);
      for (int n = 0; n < length; n++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_item('{msg_byte: 8'($urandom), byte_valid: 1'b0, msg_last: 1'b0});
         send_item('{msg_byte: 8'($urandom), byte_valid: 1'b1,
                     msg_last: (!separate_end && n == length - 1)});
      end
      if (separate_end || length == 0)
         send_item('{msg_byte: 8'($urandom), byte_valid: 1'b0, msg_last: 1'b1});
   endtask

   task automatic wait_digests();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_digest_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_message();
      send_item('{msg_byte: 8'hff, byte_valid: 1'b0, msg_last: 1'b1});
      wait_digests();
   endtask

   task automatic test_idle_items();
      send_item('{msg_byte: 8'h5a, byte_valid: 1'b0, msg_last: 1'b0});
      send_item('{msg_byte: 8'ha5, byte_valid: 1'b0, msg_last: 1'b0});
      send_item('{msg_byte: 8'hff, byte_valid: 1'b1, msg_last: 1'b1});
      wait_digests();
   endtask

   task automatic test_single_bytes();
      send_item('{msg_byte: 8'h00, byte_valid: 1'b1, msg_last: 1'b1});
      send_item('{msg_byte: 8'h80, byte_valid: 1'b1, msg_last: 1'b1});
      send_item('{msg_byte: 8'h55, byte_valid: 1'b1, msg_last: 1'b1});
      send_item('{msg_byte: 8'haa, byte_valid: 1'b1, msg_last: 1'b1});
      wait_digests();
   endtask

   task automatic test_short_messages();
      send_item('{msg_byte: 8'h61, byte_valid: 1'b1, msg_last: 1'b0});
      send_item('{msg_byte: 8'h62, byte_valid: 1'b1, msg_last: 1'b0});
      send_item('{msg_byte: 8'h63, byte_valid: 1'b1, msg_last: 1'b1});
      send_item('{msg_byte: 8'h61, byte_valid: 1'b1, msg_last: 1'b0});
      send_item('{msg_byte: 8'h62, byte_valid: 1'b1, msg_last: 1'b0});
      send_item('{msg_byte: 8'h00, byte_valid: 1'b0, msg_last: 1'b0});
      send_item('{msg_byte: 8'h63, byte_valid: 1'b1, msg_last: 1'b0});
      send_item('{msg_byte: 8'h7f, byte_valid: 1'b0, msg_last: 1'b1});
      wait_digests();
   endtask

   task automatic test_stalled_receiver();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_cycles = PRESSURE_HOLD;
      for (int m = 0; m < 4; m++) send_message($urandom_range(1, 4), 1'b0, 0);
      wait_digests();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_random_messages();
      int unsigned pick;
      int unsigned length;
      while (sent_items < ITEM_TARGET) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 15);
         if (pick < 10) length = $urandom_range(0, 12);
         else if (pick < 12) length = $urandom_range(52, 59);
         else if (pick < 14) length = $urandom_range(60, 68);
         else if (pick < 15) length = $urandom_range(116, 123);
         else length = 0;
         send_message(length, ($urandom_range(0, 3) == 0), ($urandom_range(0, 1) ? 10 : 0));
      end
      wait_digests();
   endtask

   // receiver ready with per-transaction wait and an optional long hold
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (rsp_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : digest_check
      sha256_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_wait = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (pending_digest_words.size() == 0) begin
            report_mismatch("unexpected digest transaction", rsp_data.digest_word, '0);
         end else begin
            want = pending_digest_words.pop_front();
            if (rsp_data.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp_data.digest_word, want.digest_word);
            if (rsp_data.word_index !== want.word_index)
               report_mismatch("word_index", 32'(rsp_data.word_index), 32'(want.word_index));
            if (rsp_data.digest_last !== want.digest_last)
               report_mismatch("digest_last", 32'(rsp_data.digest_last), 32'(want.digest_last));
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      start_new_message();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_message();
      test_idle_items();
      test_single_bytes();
      test_short_messages();
      test_stalled_receiver();
      test_random_messages();
      repeat (QUIET_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sha256_stream_hasher_top.f
hdl/sha256_pkg.sv
hdl/sha256_dp.sv
hdl/sha256_ctrl.sv
hdl/sha256_stream_hasher_top.sv
tb/sha256_stream_hasher_top_tb.sv
